@@ rtl/pia_pkg.sv @@
// shared types, constants and helpers for the priority indicator arbiter
`timescale 1ns / 1ps
`default_nettype none
package pia_pkg;

  // default slot count and fixed limits
  localparam int unsigned SOURCES_DEF = 16;
  localparam int unsigned EVENTS      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CNT_W       = 7;

  // effect code shown when nothing is active
  localparam logic [15:0] EFFECT_OFF = 16'd0;

  // register reset values
  localparam logic [4:0] SOURCE_COUNT_RST   = 5'd16;
  localparam logic [2:0] DEFAULT_OUTPUT_RST = 3'd0;

  // register indexes, taken from paddr[2]
  localparam logic REG_SOURCE_COUNT   = 1'b0;
  localparam logic REG_DEFAULT_OUTPUT = 1'b1;

  // command codes
  typedef enum logic [1:0] {
    FUNC_RAISE     = 2'd0,
    FUNC_CLEAR_SRC = 2'd1,
    FUNC_CLEAR_EVT = 2'd2,
    FUNC_ADVANCE   = 2'd3
  } func_t;

  // one command transaction
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  src_slot;
    logic [4:0]  evt_id;
    logic [7:0]  event_priority;
    logic [31:0] event_duration;
    logic [15:0] event_effect;
    logic [2:0]  event_output;
    logic [31:0] elapsed;
  } pia_in_t;

  // one result transaction
  typedef struct packed {
    logic        status;
    logic        shown_active;
    logic [3:0]  shown_source;
    logic [4:0]  shown_event;
    logic [2:0]  shown_output;
    logic [15:0] shown_effect;
    logic [7:0]  shown_priority;
    logic        changed;
  } pia_out_t;

  // classified command held in the queue
  typedef struct packed {
    pia_in_t item;
    logic    not_found;
  } pia_cmd_t;

  // number of slots in use: register value clamped to the slot count
  function automatic logic [CNT_W-1:0] used_count(logic [4:0] sc, int unsigned sources);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(sources);
    return ({2'b00, sc} > lim) ? lim : {2'b00, sc};
  endfunction

endpackage
`default_nettype wire

@@ rtl/pia_queue.sv @@
// short command queue between the front and back halves
`timescale 1ns / 1ps
`default_nettype none
module pia_queue #(
  parameter int unsigned DEPTH = pia_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire pia_pkg::pia_cmd_t push_data,
  output logic                   ready,
  input  wire logic              pop,
  output pia_pkg::pia_cmd_t      pop_data,
  output logic                   valid
);
  import pia_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pia_cmd_t        entry [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  // status
  assign ready    = (count != CW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entry[rd_ptr];
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/pia_front.sv @@
// command intake: accepts a transaction, checks its addressing, feeds the queue
`timescale 1ns / 1ps
`default_nettype none
module pia_front #(
  parameter int unsigned SOURCES = pia_pkg::SOURCES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire pia_pkg::pia_in_t  cmd,
  input  wire logic [4:0]        source_count,
  output logic                   push,
  output pia_pkg::pia_cmd_t      push_cmd,
  input  wire logic              push_ready
);
  import pia_pkg::*;

  logic [CNT_W-1:0] n;
  logic             src_bad;
  logic             evt_bad;
  logic             nf;
  logic             take;
  pia_cmd_t         held;
  logic             held_valid;

  // classify: unused source or unknown event is reported not found
  always_comb begin
    n       = used_count(source_count, SOURCES);
    src_bad = ({3'b000, cmd.src_slot} >= n);
    evt_bad = (32'(cmd.evt_id) >= 32'(EVENTS));
    case (cmd.func)
      FUNC_RAISE:     nf = src_bad || evt_bad;
      FUNC_CLEAR_SRC: nf = src_bad;
      default:        nf = 1'b0;
    endcase
  end

  assign busy     = held_valid && !push_ready;
  assign take     = start && !busy;
  assign push     = held_valid;
  assign push_cmd = held;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (push_ready) begin
      held_valid <= 1'b0;
    end
    if (take) begin
      held.item      <= cmd;
      held.not_found <= nf;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pia_back.sv @@
// command execution: slot updates, expiry, and the grouped priority scan
`timescale 1ns / 1ps
`default_nettype none
module pia_back #(
  parameter int unsigned SOURCES = pia_pkg::SOURCES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire pia_pkg::pia_cmd_t q_cmd,
  input  wire logic [4:0]        source_count,
  input  wire logic [2:0]        default_output,
  output logic                   done,
  output pia_pkg::pia_out_t      result
);
  import pia_pkg::*;

  localparam int unsigned SW     = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned GROUPS = (SOURCES + 3) / 4;
  localparam int unsigned GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned PAD    = GROUPS * 4;
  localparam int unsigned PIW    = GW + 2;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_EXPIRE, ST_SCAN} state_t;

  typedef struct packed {
    logic           act;
    logic [PIW-1:0] idx;
    logic [7:0]     pri;
    logic [31:0]    order;
    logic [4:0]     evt;
    logic [15:0]    eff;
    logic [2:0]     outp;
  } cand_t;

  // slot storage
  logic        slot_active   [SOURCES];
  logic [7:0]  slot_priority [SOURCES];
  logic [31:0] slot_order    [SOURCES];
  logic [63:0] slot_expiry   [SOURCES];
  logic        slot_timed    [SOURCES];
  logic [4:0]  slot_event    [SOURCES];
  logic [15:0] slot_effect   [SOURCES];
  logic [2:0]  slot_output   [SOURCES];

  state_t           state;
  pia_cmd_t         cur;
  logic             nf;
  logic [GW-1:0]    grp;
  cand_t            best;
  logic [31:0]      order_counter;
  logic [63:0]      time_now;
  logic             last_active;
  logic [2:0]       last_output;
  logic [15:0]      last_effect;

  logic [CNT_W-1:0] n;
  logic [SOURCES-1:0] evt_hit;
  logic [SOURCES-1:0] exp_hit;
  logic             raise_we;
  logic             src_clr;
  logic             evt_clr;
  logic             exp_clr;
  logic [SW-1:0]    src_sel;
  cand_t            pad   [PAD];
  cand_t            c     [4];
  cand_t            grp_best;
  cand_t            new_best;
  logic             last_grp;
  logic [2:0]       s_out;
  logic [15:0]      s_eff;
  logic             s_changed;

  // later candidate wins only when strictly ahead on priority, then order
  function automatic cand_t pick(cand_t lo, cand_t hi);
    return (hi.act && (!lo.act || {hi.pri, hi.order} > {lo.pri, lo.order})) ? hi : lo;
  endfunction

  assign n       = used_count(source_count, SOURCES);
  assign src_sel = SW'(cur.item.src_slot);
  assign q_pop   = (state == ST_IDLE) && q_valid;

  // per-slot match for clear event and expiry
  always_comb begin
    for (int i = 0; i < SOURCES; i++) begin
      evt_hit[i] = slot_active[i] && (CNT_W'(i) < n) &&
                   (slot_event[i] == cur.item.evt_id);
      exp_hit[i] = slot_active[i] && slot_timed[i] && (CNT_W'(i) < n) &&
                   (slot_expiry[i] <= time_now);
    end
  end

  // slot write enables
  always_comb begin
    raise_we = (state == ST_EXEC) && !cur.not_found && (cur.item.func == FUNC_RAISE);
    src_clr  = (state == ST_EXEC) && !cur.not_found && (cur.item.func == FUNC_CLEAR_SRC);
    evt_clr  = (state == ST_EXEC) && (cur.item.func == FUNC_CLEAR_EVT);
    exp_clr  = (state == ST_EXPIRE);
  end

  // padded candidate view, slots past the count never compete
  for (genvar i = 0; i < PAD; i++) begin : g_pad
    if (i < SOURCES) begin : g_slot
      assign pad[i] = '{act:   slot_active[i] && (CNT_W'(i) < n),
                        idx:   PIW'(i),
                        pri:   slot_priority[i],
                        order: slot_order[i],
                        evt:   slot_event[i],
                        eff:   slot_effect[i],
                        outp:  slot_output[i]};
    end else begin : g_none
      assign pad[i] = '0;
    end
  end

  // one group of four per scan cycle, folded into the running best
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c[k] = pad[{grp, 2'(k)}];
    end
    grp_best = pick(pick(c[0], c[1]), pick(c[2], c[3]));
    new_best = pick(best, grp_best);
    last_grp = (grp == GW'(GROUPS - 1));
    s_out    = new_best.act ? new_best.outp : default_output;
    s_eff    = new_best.act ? new_best.eff : EFFECT_OFF;
    s_changed = !nf && ((new_best.act != last_active) || (s_out != last_output) ||
                        (s_eff != last_effect));
  end

  // slot updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SOURCES; i++) begin
        slot_active[i] <= 1'b0;
        slot_timed[i]  <= 1'b0;
      end
    end else begin
      for (int i = 0; i < SOURCES; i++) begin
        if ((evt_clr && evt_hit[i]) || (exp_clr && exp_hit[i])) begin
          slot_active[i] <= 1'b0;
          slot_timed[i]  <= 1'b0;
        end
      end
      if (src_clr) begin
        slot_active[src_sel] <= 1'b0;
        slot_timed[src_sel]  <= 1'b0;
      end
      if (raise_we) begin
        slot_active[src_sel]   <= 1'b1;
        slot_priority[src_sel] <= cur.item.event_priority;
        slot_order[src_sel]    <= order_counter + 32'd1;
        slot_timed[src_sel]    <= (cur.item.event_duration != 32'd0);
        slot_expiry[src_sel]   <= time_now + 64'(cur.item.event_duration);
        slot_event[src_sel]    <= cur.item.evt_id;
        slot_effect[src_sel]   <= cur.item.event_effect;
        slot_output[src_sel]   <= cur.item.event_output;
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      order_counter <= '0;
      time_now      <= '0;
      last_active   <= 1'b0;
      last_output   <= 3'd0;
      last_effect   <= EFFECT_OFF;
      grp           <= '0;
      best          <= '0;
      nf            <= 1'b0;
    end else begin
      done <= (state == ST_SCAN) && last_grp;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur   <= q_cmd;
            nf    <= q_cmd.not_found;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          grp  <= '0;
          best <= '0;
          case (cur.item.func)
            FUNC_RAISE: begin
              if (!cur.not_found) begin
                order_counter <= order_counter + 32'd1;
              end
              state <= ST_SCAN;
            end
            FUNC_CLEAR_EVT: begin
              nf    <= ~|evt_hit;
              state <= ST_SCAN;
            end
            FUNC_ADVANCE: begin
              time_now <= time_now + 64'(cur.item.elapsed);
              state    <= ST_EXPIRE;
            end
            default: begin
              state <= ST_SCAN;
            end
          endcase
        end
        ST_EXPIRE: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          best <= new_best;
          grp  <= grp + 1'b1;
          if (last_grp) begin
            result.status         <= nf;
            result.shown_active   <= new_best.act;
            result.shown_source   <= new_best.act ? 4'(new_best.idx) : 4'd0;
            result.shown_event    <= new_best.act ? new_best.evt : 5'd0;
            result.shown_output   <= s_out;
            result.shown_effect   <= s_eff;
            result.shown_priority <= new_best.act ? new_best.pri : 8'd0;
            result.changed        <= s_changed;
            if (!nf) begin
              last_active <= new_best.act;
              last_output <= s_out;
              last_effect <= s_eff;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only follows the final scan step
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_SCAN))
    else $error("result strobe without a preceding scan");

  // a not-found command never reports a change
  a_nf_no_change: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> !result.changed)
    else $error("change flagged on a not-found command");

  // empty selection shows the off effect and zero priority
  a_idle_shown: assert property (@(posedge clk) disable iff (rst)
    (done && !result.shown_active) |->
      (result.shown_effect == EFFECT_OFF && result.shown_priority == 8'd0))
    else $error("inactive selection shows a live effect");

  // a popped command is executed next
  a_pop_exec: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_EXEC))
    else $error("popped command not executed");
`endif

endmodule
`default_nettype wire

@@ rtl/priority_indicator_arbiter.sv @@
// top level: config registers, command intake, queue and execution back end
// a command passes the front holding register, the queue and the back end's idle,
// exec and scan states before done rises; advance time adds the expiry state
// the back end runs one command at a time, paced by the scan that folds four slots
// a cycle; the front and the queue take new commands while the back end works
// results are strobed on done for one cycle; the receiver cannot stall
// reset: synchronous, clears all slots, time, sequence count and shown state
`timescale 1ns / 1ps
`default_nettype none
module priority_indicator_arbiter #(
  parameter int unsigned SOURCES = pia_pkg::SOURCES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire pia_pkg::pia_in_t cmd,
  output logic                  done,
  output pia_pkg::pia_out_t     result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import pia_pkg::*;

  logic [4:0] source_count;
  logic [2:0] default_output;
  logic       cfg_we;
  logic       push;
  pia_cmd_t   push_cmd;
  logic       push_ready;
  logic       q_valid;
  logic       q_pop;
  pia_cmd_t   q_cmd;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_DEFAULT_OUTPUT) ? {29'd0, default_output}
                                                   : {27'd0, source_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count   <= SOURCE_COUNT_RST;
      default_output <= DEFAULT_OUTPUT_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_SOURCE_COUNT) begin
        source_count <= pwdata[4:0];
      end else begin
        default_output <= pwdata[2:0];
      end
    end
  end

  // intake and classification
  pia_front #(.SOURCES(SOURCES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .source_count (source_count),
    .push         (push),
    .push_cmd     (push_cmd),
    .push_ready   (push_ready)
  );

  // command queue
  pia_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .ready     (push_ready),
    .pop       (q_pop),
    .pop_data  (q_cmd),
    .valid     (q_valid)
  );

  // execution and selection
  pia_back #(.SOURCES(SOURCES)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_cmd          (q_cmd),
    .source_count   (source_count),
    .default_output (default_output),
    .done           (done),
    .result         (result)
  );

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench for the priority indicator arbiter: directed and random commands checked by a predictor
`timescale 1ns / 1ps
module testbench;
  import pia_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int NUM_SLOTS  = 16;
  localparam int MAX_GAP    = 13;
  localparam int SETTLE     = 24;
  localparam int LIMIT      = 400000;
  localparam int PHASE_LEN  = 140;

  // predicts the shown selection per command and checks each result transaction
  class indicator_board;
    logic        slot_on[NUM_SLOTS];
    logic [7:0]  slot_pri[NUM_SLOTS];
    logic [31:0] slot_seq[NUM_SLOTS];
    logic [63:0] slot_deadline[NUM_SLOTS];
    logic        slot_timed[NUM_SLOTS];
    logic [4:0]  slot_evt[NUM_SLOTS];
    logic [15:0] slot_fx[NUM_SLOTS];
    logic [2:0]  slot_out[NUM_SLOTS];
    logic [31:0] seq_count;
    logic [63:0] now_ms;
    logic        last_on;
    logic [2:0]  last_out;
    logic [15:0] last_fx;
    logic [4:0]  src_count;
    logic [2:0]  default_out;
    pia_out_t    shown_queue[$];
    int          errors;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) clear_slot(i);
      seq_count   = '0;
      now_ms      = '0;
      last_on     = 1'b0;
      last_out    = '0;
      last_fx     = EFFECT_OFF;
      src_count   = SOURCE_COUNT_RST;
      default_out = DEFAULT_OUTPUT_RST;
      errors      = 0;
    endfunction

    function void clear_slot(int i);
      slot_on[i]       = 1'b0;
      slot_pri[i]      = '0;
      slot_seq[i]      = '0;
      slot_deadline[i] = '0;
      slot_timed[i]    = 1'b0;
      slot_evt[i]      = '0;
      slot_fx[i]       = '0;
      slot_out[i]      = '0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_SOURCE_COUNT) src_count = value[4:0];
      else default_out = value[2:0];
    endfunction

    function int pending();
      return shown_queue.size();
    endfunction

    // apply one accepted command, then work out the selection it shows
    function void note_command(pia_in_t c);
      int       n;
      int       pick;
      logic     miss;
      logic     found;
      pia_out_t e;
      n     = (src_count > NUM_SLOTS) ? NUM_SLOTS : int'(src_count);
      miss  = 1'b0;
      found = 1'b0;
      case (func_t'(c.func))
        FUNC_RAISE: begin
          if (c.src_slot >= n || c.evt_id >= EVENTS) begin
            miss = 1'b1;
          end else begin
            seq_count                = seq_count + 32'd1;
            slot_on[c.src_slot]       = 1'b1;
            slot_pri[c.src_slot]      = c.event_priority;
            slot_seq[c.src_slot]      = seq_count;
            slot_timed[c.src_slot]    = (c.event_duration != 0);
            slot_deadline[c.src_slot] = (c.event_duration != 0) ?
                                        now_ms + 64'(c.event_duration) : 64'd0;
            slot_evt[c.src_slot]      = c.evt_id;
            slot_fx[c.src_slot]       = c.event_effect;
            slot_out[c.src_slot]      = c.event_output;
          end
        end
        FUNC_CLEAR_SRC: begin
          if (c.src_slot >= n) miss = 1'b1;
          else clear_slot(int'(c.src_slot));
        end
        FUNC_CLEAR_EVT: begin
          for (int i = 0; i < n; i++) begin
            if (slot_on[i] && slot_evt[i] == c.evt_id) begin
              clear_slot(i);
              found = 1'b1;
            end
          end
          miss = !found;
        end
        default: begin
          now_ms = now_ms + 64'(c.elapsed);
          for (int i = 0; i < n; i++) begin
            if (slot_on[i] && slot_timed[i] && slot_deadline[i] <= now_ms) clear_slot(i);
          end
        end
      endcase

      // highest priority wins, newest raise on a tie
      pick = -1;
      for (int i = 0; i < n; i++) begin
        if (slot_on[i]) begin
          if (pick < 0 || slot_pri[i] > slot_pri[pick] ||
              (slot_pri[i] == slot_pri[pick] && slot_seq[i] > slot_seq[pick]))
            pick = i;
        end
      end

      e = '0;
      e.status       = miss;
      e.shown_active = (pick >= 0);
      e.shown_output = default_out;
      e.shown_effect = EFFECT_OFF;
      if (pick >= 0) begin
        e.shown_source   = 4'(pick);
        e.shown_event    = slot_evt[pick];
        e.shown_output   = slot_out[pick];
        e.shown_effect   = slot_fx[pick];
        e.shown_priority = slot_pri[pick];
      end
      if (!miss) begin
        e.changed = (e.shown_active != last_on) || (e.shown_output != last_out) ||
                    (e.shown_effect != last_fx);
        last_on  = e.shown_active;
        last_out = e.shown_output;
        last_fx  = e.shown_effect;
      end
      shown_queue.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // compare one result transaction with the oldest prediction
    function void check_shown(pia_out_t got);
      pia_out_t want;
      if (shown_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      want = shown_queue.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("shown_active", 32'(want.shown_active), 32'(got.shown_active));
      compare_field("shown_source", 32'(want.shown_source), 32'(got.shown_source));
      compare_field("shown_event", 32'(want.shown_event), 32'(got.shown_event));
      compare_field("shown_output", 32'(want.shown_output), 32'(got.shown_output));
      compare_field("shown_effect", 32'(want.shown_effect), 32'(got.shown_effect));
      compare_field("shown_priority", 32'(want.shown_priority), 32'(got.shown_priority));
      compare_field("changed", 32'(want.changed), 32'(got.changed));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  pia_in_t     cmd;
  logic        done;
  pia_out_t    result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  indicator_board board;
  int             used_now;
  int             cycle_count;
  logic           burst;

  priority_indicator_arbiter #(.SOURCES(NUM_SLOTS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) board.check_shown(result);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic pia_in_t make_command(func_t f, int src, int ev, int pri,
                                           logic [31:0] dur, logic [15:0] fx,
                                           int outp, logic [31:0] el);
    pia_in_t c;
    c.func           = f;
    c.src_slot       = 4'(src);
    c.evt_id         = 5'(ev);
    c.event_priority = 8'(pri);
    c.event_duration = dur;
    c.event_effect   = fx;
    c.event_output   = 3'(outp);
    c.elapsed        = el;
    return c;
  endfunction

  // random command: mostly in-range sources, few events and priorities so that
  // ties, clears and expiries happen often; unused fields carry noise
  function automatic pia_in_t random_command(int used);
    logic [127:0] noise;
    pia_in_t      c;
    int unsigned  roll;
    noise = {$urandom, $urandom, $urandom, $urandom};
    c     = noise[$bits(pia_in_t)-1:0];
    roll  = $urandom_range(0, 99);
    if (roll < 45) c.func = FUNC_RAISE;
    else if (roll < 60) c.func = FUNC_CLEAR_SRC;
    else if (roll < 72) c.func = FUNC_CLEAR_EVT;
    else c.func = FUNC_ADVANCE;
    if (used > 0 && $urandom_range(0, 4) != 0) c.src_slot = 4'($urandom_range(0, used - 1));
    if ($urandom_range(0, 3) != 0) c.evt_id = 5'($urandom_range(0, 3));
    if ($urandom_range(0, 2) != 0) c.event_priority = 8'($urandom_range(0, 3));
    roll = $urandom_range(0, 9);
    if (roll < 3) c.event_duration = '0;
    else if (roll < 8) c.event_duration = 32'($urandom_range(1, 40));
    roll = $urandom_range(0, 9);
    if (roll < 8) c.elapsed = 32'($urandom_range(0, 15));
    else if (roll == 8) c.elapsed = '0;
    return c;
  endfunction

  task automatic send_command(input pia_in_t c, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    board.note_command(c);
  endtask

  // wait until every expected result is back and the block has settled
  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int count, input int dout);
    drain();
    write_register(REG_SOURCE_COUNT, {27'($urandom), 5'(count)});
    write_register(REG_DEFAULT_OUTPUT, {29'($urandom), 3'(dout)});
    used_now = (count > NUM_SLOTS) ? NUM_SLOTS : count;
  endtask

  task automatic run_random(input int items);
    for (int k = 0; k < items; k++) begin
      if (k % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) == 0) drain();
      send_command(random_command(used_now), draw_gap());
    end
  endtask

  // stimulus
  initial begin
    board       = new();
    cycle_count = 0;
    burst       = 1'b0;
    used_now    = NUM_SLOTS;
    rst     <= 1'b1;
    start   <= 1'b0;
    cmd     <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // empty block, field extremes, ties, expiry and clears
    send_command(make_command(FUNC_CLEAR_EVT, 0, 9, 0, 0, 0, 0, 0), draw_gap());
    send_command(make_command(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 0), draw_gap());
    send_command(make_command(FUNC_RAISE, 0, 0, 0, 0, 16'h0000, 0, 0), draw_gap());
    send_command(make_command(FUNC_RAISE, 15, 31, 255, 32'hFFFF_FFFF, 16'hFFFF, 7,
                              32'hFFFF_FFFF), draw_gap());
    send_command(make_command(FUNC_RAISE, 3, 7, 255, 10, 16'h1234, 2, 0), draw_gap());
    send_command(make_command(FUNC_RAISE, 12, 7, 254, 0, 16'h0055, 5, 0), draw_gap());
    send_command(make_command(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 9), draw_gap());
    send_command(make_command(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 1), draw_gap());
    send_command(make_command(FUNC_CLEAR_SRC, 15, 0, 0, 0, 0, 0, 0), draw_gap());
    send_command(make_command(FUNC_CLEAR_EVT, 0, 7, 0, 0, 0, 0, 0), draw_gap());
    send_command(make_command(FUNC_CLEAR_SRC, 2, 0, 0, 0, 0, 0, 0), draw_gap());
    send_command(make_command(FUNC_RAISE, 12, 20, 100, 0, 16'h00AA, 3, 0), draw_gap());
    send_command(make_command(FUNC_RAISE, 9, 20, 100, 5, 16'h0BB0, 4, 0), draw_gap());
    send_command(make_command(FUNC_RAISE, 10, 21, 100, 3, 16'h8001, 6, 0), draw_gap());
    send_command(make_command(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), draw_gap());
    send_command(make_command(FUNC_RAISE, 1, 22, 200, 0, 16'h0000, 0, 0), draw_gap());

    // fewer sources in use: unused sources and hidden slots
    configure(4, 5);
    send_command(make_command(FUNC_RAISE, 4, 1, 9, 0, 16'h0101, 1, 0), draw_gap());
    send_command(make_command(FUNC_CLEAR_SRC, 15, 0, 0, 0, 0, 0, 0), draw_gap());
    send_command(make_command(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 0), draw_gap());
    send_command(make_command(FUNC_CLEAR_EVT, 0, 20, 0, 0, 0, 0, 0), draw_gap());
    configure(16, 7);
    send_command(make_command(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 0), draw_gap());
    send_command(make_command(FUNC_CLEAR_SRC, 1, 0, 0, 0, 0, 0, 0), draw_gap());

    // no source in use, then a count above the slot number
    configure(0, 2);
    send_command(make_command(FUNC_RAISE, 0, 3, 50, 0, 16'h0F0F, 3, 0), draw_gap());
    send_command(make_command(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 5), draw_gap());
    configure(31, 6);
    send_command(make_command(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 0), draw_gap());

    // random phases over several settings
    configure(16, 0);
    run_random(PHASE_LEN);
    configure(1, 7);
    run_random(PHASE_LEN);
    configure(31, 3);
    run_random(PHASE_LEN);
    configure(0, 4);
    run_random(PHASE_LEN);
    configure(5, 1);
    run_random(PHASE_LEN);
    configure(16, 7);
    run_random(PHASE_LEN);
    configure(2, 0);
    run_random(PHASE_LEN);
    configure($urandom_range(0, 31), $urandom_range(0, 7));
    run_random(PHASE_LEN);
    configure($urandom_range(1, 16), $urandom_range(0, 7));
    run_random(PHASE_LEN);

    // wait out the last results
    drain();
    if (board.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pia_pkg.sv
rtl/pia_queue.sv
rtl/pia_front.sv
rtl/pia_back.sv
rtl/priority_indicator_arbiter.sv
tb/sv/testbench.sv
